### rtl/core/led_pkg.sv
// Shared types and constants of the literal escape decoder.
package led_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LEAD   = 4'd1,
    PH_RAW    = 4'd2,
    PH_ESC    = 4'd3,
    PH_HEX    = 4'd4,
    PH_UBRACE = 4'd5,
    PH_UDIG   = 4'd6,
    PH_USKIP  = 4'd7,
    PH_CHECK  = 4'd8,
    PH_TAIL   = 4'd9
  } phase_e;

  localparam int unsigned VAL_W = 21;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_EXTRA = 2'd2;

  localparam logic [VAL_W-1:0] MAX_CODE  = 21'h10FFFF;
  localparam logic [VAL_W-1:0] ASCII_TOP = 21'h00007F;
  localparam logic [5:0]       CONT_MASK = 6'h3F;

  localparam int unsigned QDEPTH = 2;

  // one queued job: a single result, or a value to be sent as UTF-8
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       error_code;
    logic             encode;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

### rtl/core/led_in_if.sv
// Input channel of the literal escape decoder: one token byte per item.
interface led_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;
  logic       end_of_token;

  modport source (output valid, mode, char_byte, end_of_token, input ready);
  modport sink   (input valid, mode, char_byte, end_of_token, output ready);
endinterface

### rtl/core/led_out_if.sv
// Output channel of the literal escape decoder: one decoded value per item.
interface led_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] out_value;
  logic        last_of_run;
  logic [1:0]  error_code;

  modport source (output valid, out_value, last_of_run, error_code, input ready);
  modport sink   (input valid, out_value, last_of_run, error_code, output ready);
endinterface

### rtl/core/led_front.sv
// Front end: token byte classifier and escape decoder, emits at most one job per item.
module led_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  led_in_if.sink           in_i,
  input  logic             q_full_i,
  output led_pkg::push_t   push_o
);
  import led_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] r;
    r = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) r = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) r = 4'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) r = 4'(b - 8'h41 + 8'd10);
    return r;
  endfunction

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd1;
    if ((b & 8'hE0) == 8'hC0) r = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) r = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) r = 3'd4;
    return r;
  endfunction

  phase_e           phase_q, phase_d, phase_nx;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             hds_q, hds_d;
  logic [1:0]       pend_q, pend_d;

  logic             accept;
  logic             mode;
  logic [7:0]       b;
  logic             eot;
  logic [2:0]       n;
  logic [3:0]       hexv;
  logic [24:0]      t;
  logic             t_over;
  logic [1:0]       pend_dec;
  logic [VAL_W-1:0] acc_raw;
  logic [7:0]       hex_acc;
  logic [7:0]       esc_val;
  phase_e           fin_ph;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign mode       = in_i.mode;
  assign b          = in_i.char_byte;
  assign eot        = in_i.end_of_token;
  assign n          = seq_len(b);
  assign hexv       = hex_value(b);
  assign t          = {acc_q, 4'b0000} + {21'd0, hexv};
  assign t_over     = t > {4'd0, MAX_CODE};
  assign pend_dec   = pend_q - 2'd1;
  assign acc_raw    = {acc_q[14:0], b[5:0] & CONT_MASK};
  assign hex_acc    = {acc_q[3:0], hexv};
  assign fin_ph     = mode ? PH_CHECK : PH_LEAD;

  always_comb begin
    unique case (b)
      CH_N:      esc_val = 8'h0A;
      CH_T:      esc_val = 8'h09;
      CH_R:      esc_val = 8'h0D;
      CH_BSLASH: esc_val = CH_BSLASH;
      CH_SQUOTE: esc_val = CH_SQUOTE;
      CH_DQUOTE: esc_val = CH_DQUOTE;
      default:   esc_val = 8'h00;
    endcase
  end

  // next phase
  always_comb begin
    phase_nx = phase_q;
    unique case (phase_q)
      PH_IDLE:   phase_nx = PH_LEAD;
      PH_LEAD: begin
        if (b == CH_BSLASH) phase_nx = PH_ESC;
        else if (!mode && b == CH_DQUOTE) phase_nx = PH_TAIL;
        else if (n == 3'd1) phase_nx = mode ? PH_CHECK : PH_LEAD;
        else phase_nx = PH_RAW;
      end
      PH_RAW:    phase_nx = (pend_dec == 2'd0) ? fin_ph : PH_RAW;
      PH_ESC: begin
        if (b == CH_X) phase_nx = PH_HEX;
        else if (b == CH_U) phase_nx = PH_UBRACE;
        else phase_nx = fin_ph;
      end
      PH_HEX:    phase_nx = hds_q ? fin_ph : PH_HEX;
      PH_UBRACE: phase_nx = PH_UDIG;
      PH_UDIG: begin
        if (b == CH_RBRACE || eot) phase_nx = fin_ph;
        else if (t_over) phase_nx = PH_USKIP;
        else phase_nx = PH_UDIG;
      end
      PH_USKIP:  phase_nx = (b == CH_RBRACE) ? fin_ph : PH_USKIP;
      PH_CHECK:  phase_nx = PH_TAIL;
      PH_TAIL:   phase_nx = PH_TAIL;
      default:   phase_nx = PH_IDLE;
    endcase
    if (eot) phase_nx = PH_IDLE;
    phase_d = accept ? phase_nx : phase_q;
  end

  // datapath and job output
  always_comb begin
    acc_d                  = acc_q;
    hds_d                  = hds_q;
    pend_d                 = pend_q;
    push_o.valid           = 1'b0;
    push_o.job.value       = '0;
    push_o.job.error_code  = ERR_NONE;
    push_o.job.encode      = 1'b0;
    unique case (phase_q)
      PH_LEAD: begin
        if (b != CH_BSLASH && !(!mode && b == CH_DQUOTE)) begin
          if (!mode || n == 3'd1) begin
            push_o.valid     = 1'b1;
            push_o.job.value = {13'd0, b};
          end
          if (mode && n != 3'd1) acc_d = {13'd0, b & (8'h7F >> n)};
          if (n != 3'd1) pend_d = 2'(n - 3'd1);
        end
      end
      PH_RAW: begin
        pend_d = pend_dec;
        if (mode) begin
          acc_d = acc_raw;
          if (pend_dec == 2'd0) begin
            push_o.valid     = 1'b1;
            push_o.job.value = acc_raw;
          end
        end else begin
          push_o.valid     = 1'b1;
          push_o.job.value = {13'd0, b};
        end
      end
      PH_ESC: begin
        acc_d = '0;
        hds_d = 1'b0;
        if (b != CH_X && b != CH_U) begin
          push_o.valid      = 1'b1;
          push_o.job.value  = {13'd0, esc_val};
          push_o.job.encode = !mode;
        end
      end
      PH_HEX: begin
        acc_d = {13'd0, hex_acc};
        if (hds_q) begin
          hds_d             = 1'b0;
          push_o.valid      = 1'b1;
          push_o.job.value  = {13'd0, hex_acc};
          push_o.job.encode = !mode;
        end else begin
          hds_d = 1'b1;
        end
      end
      PH_UBRACE: acc_d = '0;
      PH_UDIG: begin
        if (b == CH_RBRACE || eot) begin
          push_o.valid      = 1'b1;
          push_o.job.value  = acc_q;
          push_o.job.encode = !mode;
        end else if (t_over) begin
          acc_d                 = '0;
          push_o.valid          = 1'b1;
          push_o.job.error_code = ERR_RANGE;
          push_o.job.encode     = !mode;
        end else begin
          acc_d = t[VAL_W-1:0];
        end
      end
      PH_CHECK: begin
        if (b != CH_SQUOTE && !eot) begin
          push_o.valid          = 1'b1;
          push_o.job.error_code = ERR_EXTRA;
        end
      end
      default: ;
    endcase
    if (eot) begin
      acc_d  = '0;
      hds_d  = 1'b0;
      pend_d = 2'd0;
    end
    if (!accept) begin
      acc_d        = acc_q;
      hds_d        = hds_q;
      pend_d       = pend_q;
      push_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      hds_q   <= 1'b0;
      pend_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hds_q   <= hds_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### rtl/core/led_queue.sv
// Two-entry job queue between the front end and the result sequencer.
module led_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  led_pkg::push_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output led_pkg::head_t head_o
);
  import led_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o      = count_q == CNT_W'(QDEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    else if (!do_push && do_pop) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

endmodule

### rtl/core/led_back.sv
// Back end: expands queued jobs into result items, UTF-8 encoding where asked.
module led_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  led_pkg::head_t head_i,
  output logic           pop_o,
  led_out_if.source      out_o
);
  import led_pkg::*;

  logic             valid_q, valid_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             last_q, last_d;
  logic [1:0]       err_q, err_d;
  logic [1:0]       idx_q, idx_d;
  logic [1:0]       lm1;
  logic [1:0]       rem;
  logic [VAL_W-1:0] v, sh;
  logic [7:0]       byte_val;
  logic             slot_free;
  logic             is_last;

  assign v = head_i.job.value;

  always_comb begin
    lm1 = 2'd0;
    if (head_i.job.encode) begin
      if (v <= ASCII_TOP) lm1 = 2'd0;
      else if (v < 21'h000800) lm1 = 2'd1;
      else if (v < 21'h010000) lm1 = 2'd2;
      else lm1 = 2'd3;
    end
  end

  assign rem = lm1 - idx_q;

  always_comb begin
    case (rem)
      2'd0:    sh = v;
      2'd1:    sh = v >> 6;
      2'd2:    sh = v >> 12;
      default: sh = v >> 18;
    endcase
  end

  always_comb begin
    byte_val = {2'b10, sh[5:0] & CONT_MASK};
    if (idx_q == 2'd0) begin
      case (lm1)
        2'd1:    byte_val = {3'b110, sh[4:0]};
        2'd2:    byte_val = {4'b1110, sh[3:0]};
        2'd3:    byte_val = {5'b11110, sh[2:0]};
        default: byte_val = sh[7:0];
      endcase
    end
  end

  assign slot_free = !valid_q || out_o.ready;
  assign is_last   = idx_q == lm1;
  assign pop_o     = slot_free && head_i.valid && is_last;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    last_d  = last_q;
    err_d   = err_q;
    idx_d   = idx_q;
    if (slot_free) begin
      valid_d = head_i.valid;
      if (head_i.valid) begin
        value_d = (lm1 == 2'd0) ? v : {13'd0, byte_val};
        last_d  = is_last;
        err_d   = head_i.job.error_code;
        idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_value   = value_q;
  assign out_o.last_of_run = last_q;
  assign out_o.error_code  = err_q;

endmodule

### rtl/core/literal_escape_decoder_top.sv
// First result of an item goes through the job queue and the output register.
// Throughput: one item per cycle, one result per cycle, each unless stalled.
// An escape sent as UTF-8 holds the result sequencer for up to four bytes; the
// two-entry job queue can then fill, and input ready drops until it drains.
// Reset (async, active low) clears decoder phase, queue and output valid.
module literal_escape_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  led_in_if.sink    in_i,
  led_out_if.source out_o
);
  import led_pkg::*;

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  led_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  led_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  led_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

### rtl/core/led_checker.sv
// Port-level assertions of the literal escape decoder and their bind.
module led_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [20:0] out_value_i,
  input logic        last_of_run_i,
  input logic [1:0]  error_code_i
);
  import led_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_value_i) && $stable(last_of_run_i) && $stable(error_code_i))
    else $error("stalled result item changed");

  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != ERR_NONE |->
      out_value_i == '0 && last_of_run_i &&
      (error_code_i == ERR_RANGE || error_code_i == ERR_EXTRA))
    else $error("bad error result");

  a_utf8_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> out_value_i[20:8] == '0 && out_value_i[7])
    else $error("non-final result is not a UTF-8 multibyte byte");

endmodule

bind literal_escape_decoder_top led_checker u_led_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_value_i   (out_o.out_value),
  .last_of_run_i (out_o.last_of_run),
  .error_code_i  (out_o.error_code)
);
